// ----- hw/rtl/mtlp_pkg.sv -----
// mtlp_pkg: shared types, character codes and defaults for the motor telemetry line parser
// no dependencies; imported by every module of the block
package mtlp_pkg;

  localparam int LINE_BYTES_DEF = 24;
  localparam int DISCARD_DEF    = 5;
  localparam int DISC_W         = 3;
  localparam int BYTE_W         = 8;
  localparam int VAL_W          = 32;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DIG0  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIG9  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
  localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
  localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
  localparam logic [BYTE_W-1:0] CH_V     = 8'h56;

  typedef enum logic [1:0] {
    LK_ENC  = 2'd0,
    LK_VOLT = 2'd1,
    LK_CUR  = 2'd2
  } line_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_BLANK,
    PH_DIGIT,
    PH_DONE
  } dec_phase_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } store_cmd_t;

  typedef struct packed {
    logic clr;
    logic feed;
  } dec_cmd_t;

  typedef struct packed {
    logic idle;
    logic load;
  } ctrl_stat_t;

  typedef struct packed {
    line_kind_t       kind;
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] second;
  } result_t;

endpackage

// ----- hw/rtl/motor_telemetry_line_parser_unit.sv -----
// motor_telemetry_line_parser_unit: top level, input handshake, line memory and result register
// depends on mtlp_pkg, mtlp_store, mtlp_ctrl
//
//   channel  signals                                        direction
//   in       in_valid, in_ready, rx_byte                    byte transaction in
//   out      out_valid, out_ready, line_kind,               result transaction out
//            first_value, second_value
//
// a byte other than carriage return is taken and stored while the line memory has room
// after a carriage return in_ready is low while the sequencer walks the line: one read per stored byte,
//   a wait for the last registered read to come back, then the drain state and the finish state
// in_ready stays low during that walk and while a result waits for a free output register
// rst is synchronous, active high; it empties the line and reloads the discard count
module motor_telemetry_line_parser_unit
  import mtlp_pkg::*;
#(
  parameter int LINE_BYTES       = LINE_BYTES_DEF,
  parameter int DISCARD_READINGS = DISCARD_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [BYTE_W-1:0]       rx_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              line_kind,
  output logic signed [VAL_W-1:0] first_value,
  output logic signed [VAL_W-1:0] second_value
);

  localparam int AW = $clog2(LINE_BYTES);

  store_cmd_t        store_cmd;
  ctrl_stat_t        stat;
  result_t           res;
  result_t           res_q;
  logic              take;
  logic              is_cr;
  logic              slot_free;
  logic [AW-1:0]     fill;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign in_ready      = stat.idle;
  assign take          = in_valid && in_ready;
  assign is_cr         = (rx_byte == CH_CR);
  assign store_cmd.wr  = take && !is_cr;
  assign store_cmd.clr = take && is_cr;
  assign slot_free     = !out_valid || out_ready;

  mtlp_store #(
    .LINE_BYTES (LINE_BYTES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (store_cmd),
    .wr_data (rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .fill    (fill)
  );

  mtlp_ctrl #(
    .LINE_BYTES       (LINE_BYTES),
    .DISCARD_READINGS (DISCARD_READINGS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (store_cmd.clr),
    .slot_free (slot_free),
    .fill      (fill),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .stat      (stat),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.load) begin
      res_q <= res;
    end
  end

  assign line_kind    = res_q.kind;
  assign first_value  = $signed(res_q.first);
  assign second_value = $signed(res_q.second);

endmodule

// ----- hw/rtl/mtlp_store.sv -----
// mtlp_store: line memory with fill count, one byte written and one byte read per cycle
// depends on mtlp_pkg
module mtlp_store
  import mtlp_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  store_cmd_t                    cmd,
  input  logic [BYTE_W-1:0]             wr_data,
  input  logic [$clog2(LINE_BYTES)-1:0] rd_addr,
  output logic [BYTE_W-1:0]             rd_data,
  output logic [$clog2(LINE_BYTES)-1:0] fill
);

  localparam int AW = $clog2(LINE_BYTES);

  logic [BYTE_W-1:0] mem [LINE_BYTES];
  logic              wr_ok;

  // one slot is kept back, extra bytes of a long line are dropped
  assign wr_ok = cmd.wr && (fill < AW'(LINE_BYTES - 1));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[fill] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.clr) begin
      fill <= '0;
    end else if (wr_ok) begin
      fill <= fill + AW'(1);
    end
  end

endmodule

// ----- hw/rtl/mtlp_dec.sv -----
// mtlp_dec: decimal field accumulator, one character per cycle while cmd.feed is high, wraps modulo 2^32
// depends on mtlp_pkg
module mtlp_dec
  import mtlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dec_cmd_t          cmd,
  input  logic [BYTE_W-1:0] data,
  output logic [VAL_W-1:0]  acc,
  output logic              neg
);

  dec_phase_t       phase, phase_next;
  logic [VAL_W-1:0] acc_next;
  logic [VAL_W-1:0] acc_x10;
  logic             neg_next;
  logic             is_digit;
  logic             is_blank;
  logic             is_sign;

  always_comb begin
    is_digit = (data >= CH_DIG0) && (data <= CH_DIG9);
    is_blank = (data == CH_SPACE) || ((data >= CH_TAB) && (data <= CH_FF));
    is_sign  = (data == CH_PLUS) || (data == CH_MINUS);
    // acc * 10 + digit as two shifts and two adds
    acc_x10  = {acc[VAL_W-4:0], 3'b000} + {acc[VAL_W-2:0], 1'b0}
             + {{(VAL_W-4){1'b0}}, data[3:0]};
    phase_next = phase;
    acc_next   = acc;
    neg_next   = neg;
    if (cmd.clr) begin
      phase_next = PH_BLANK;
      acc_next   = '0;
      neg_next   = 1'b0;
    end else if (cmd.feed) begin
      case (phase)
        PH_BLANK: begin
          if (is_blank) begin
            phase_next = PH_BLANK;
          end else if (is_sign) begin
            neg_next   = (data == CH_MINUS);
            phase_next = PH_DIGIT;
          end else if (is_digit) begin
            acc_next   = acc_x10;
            phase_next = PH_DIGIT;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_DIGIT: begin
          if (is_digit) begin
            acc_next = acc_x10;
          end else begin
            phase_next = PH_DONE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BLANK;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    neg <= neg_next;
  end

endmodule

// ----- hw/rtl/mtlp_ctrl.sv -----
// mtlp_ctrl: line-end sequencer; walks the stored bytes, matches the prefix, splits fields
// depends on mtlp_pkg and mtlp_dec
module mtlp_ctrl
  import mtlp_pkg::*;
#(
  parameter int LINE_BYTES       = LINE_BYTES_DEF,
  parameter int DISCARD_READINGS = DISCARD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          slot_free,
  input  logic [$clog2(LINE_BYTES)-1:0] fill,
  input  logic [BYTE_W-1:0]             rd_data,
  output logic [$clog2(LINE_BYTES)-1:0] rd_addr,
  output ctrl_stat_t                    stat,
  output result_t                       res
);

  localparam int AW = $clog2(LINE_BYTES);

  ctrl_state_t       state, state_next;
  logic [AW-1:0]     len;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     pos1;
  logic              v1;
  logic              m_bcr, m_ba, m_v;
  logic              found;
  line_kind_t        kind;
  logic              fidx;
  logic [VAL_W-1:0]  a_acc;
  logic              a_neg;
  logic [DISC_W-1:0] disc;

  logic              issue;
  logic              fin;
  logic              emit;
  logic              disc_dec;
  logic              hit_bcr, hit_ba, hit_v;
  logic              is_sep;
  logic              take_sep;
  logic              long_line;
  logic [VAL_W-1:0]  a_val, b_val;
  logic [VAL_W-1:0]  dec_acc;
  logic              dec_neg;
  dec_cmd_t          dec_cmd;

  mtlp_dec u_dec (
    .clk  (clk),
    .rst  (rst),
    .cmd  (dec_cmd),
    .data (rd_data),
    .acc  (dec_acc),
    .neg  (dec_neg)
  );

  // prefix match on the byte coming out of the memory
  always_comb begin
    hit_bcr = m_bcr && (((pos1 == AW'(0)) && (rd_data == CH_B)) ||
                        ((pos1 == AW'(1)) && (rd_data == CH_C)) ||
                        ((pos1 == AW'(2)) && (rd_data == CH_R)) ||
                        ((pos1 == AW'(3)) && (rd_data == CH_EQUAL)));
    hit_ba  = m_ba  && (((pos1 == AW'(0)) && (rd_data == CH_B)) ||
                        ((pos1 == AW'(1)) && (rd_data == CH_A)) ||
                        ((pos1 == AW'(2)) && (rd_data == CH_EQUAL)));
    hit_v   = m_v   && (((pos1 == AW'(0)) && (rd_data == CH_V)) ||
                        ((pos1 == AW'(1)) && (rd_data == CH_EQUAL)));
    // a zero byte also splits voltage fields
    is_sep   = (rd_data == CH_COLON) || ((kind == LK_VOLT) && (rd_data == CH_NUL));
    take_sep = v1 && found && !fidx && is_sep;
    dec_cmd.clr  = start || take_sep;
    dec_cmd.feed = v1 && found && !take_sep;
  end

  // line-end decision
  always_comb begin
    long_line = len > AW'(4);
    emit      = 1'b0;
    disc_dec  = 1'b0;
    case (kind)
      LK_ENC: begin
        emit     = found && long_line && (disc == '0) && fidx;
        disc_dec = found && long_line && (disc != '0);
      end
      LK_VOLT, LK_CUR: begin
        emit = found && fidx;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    a_val      = a_neg ? (VAL_W'(0) - a_acc) : a_acc;
    b_val      = dec_neg ? (VAL_W'(0) - dec_acc) : dec_acc;
    res.kind   = kind;
    res.first  = (kind == LK_VOLT) ? b_val : a_val;
    res.second = (kind == LK_VOLT) ? '0 : b_val;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx == len) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!emit || slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    issue     = (state == ST_SCAN) && (idx != len);
    fin       = (state == ST_FINISH);
    stat.idle = (state == ST_IDLE);
    stat.load = fin && emit && slot_free;
    rd_addr   = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      v1    <= 1'b0;
      m_bcr <= 1'b0;
      m_ba  <= 1'b0;
      m_v   <= 1'b0;
      found <= 1'b0;
      fidx  <= 1'b0;
      disc  <= DISC_W'(DISCARD_READINGS);
    end else begin
      state <= state_next;
      v1    <= issue;
      if (start) begin
        idx   <= '0;
        m_bcr <= 1'b1;
        m_ba  <= 1'b1;
        m_v   <= 1'b1;
        found <= 1'b0;
        fidx  <= 1'b0;
      end
      if (issue) begin
        idx <= idx + AW'(1);
      end
      if (v1 && !found) begin
        m_bcr <= hit_bcr;
        m_ba  <= hit_ba;
        m_v   <= hit_v;
        if ((hit_bcr && (pos1 == AW'(3))) || (hit_ba && (pos1 == AW'(2))) ||
            (hit_v && (pos1 == AW'(1)))) begin
          found <= 1'b1;
        end
      end
      if (take_sep) begin
        fidx <= 1'b1;
      end
      if (fin && disc_dec) begin
        disc <= disc - DISC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      len <= fill;
    end
    if (issue) begin
      pos1 <= idx;
    end
    if (v1 && !found) begin
      if (hit_bcr) begin
        kind <= LK_ENC;
      end else if (hit_ba) begin
        kind <= LK_CUR;
      end else if (hit_v) begin
        kind <= LK_VOLT;
      end
    end
    if (take_sep) begin
      a_acc <= dec_acc;
      a_neg <= dec_neg;
    end
  end

endmodule
